// File: hw/rtl/frcs_pkg.sv
// Package with the shared constants and types of the framed command relay switch.
`timescale 1ns / 1ps
package frcs_pkg;

  localparam int FRAME_BYTES_DEF = 11;

  localparam logic [7:0] CH_START = 8'h53;
  localparam logic [7:0] CH_END   = 8'h45;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Frame byte positions that take part in evaluation.
  localparam int POS_HDR1    = 1;
  localparam int POS_HDR2    = 2;
  localparam int POS_HDR3    = 3;
  localparam int POS_ADDR_HI = 4;
  localparam int POS_ADDR_LO = 5;
  localparam int POS_CMD     = 9;

  localparam logic [15:0] ADDRESS_ONE_RST   = 16'd12337;
  localparam logic [15:0] ADDRESS_TWO_RST   = 16'd12338;
  localparam logic [15:0] ADDRESS_THREE_RST = 16'd12339;

  typedef enum logic [1:0] {
    REG_ADDRESS_ONE,
    REG_ADDRESS_TWO,
    REG_ADDRESS_THREE
  } frcs_reg_t;

  // One classified byte handed from the front to the back.
  typedef struct packed {
    logic        frame_end;
    logic        header_ok;
    logic [15:0] addr;
    logic        cmd_on;
    logic        cmd_off;
  } frcs_cmd_t;

endpackage

// File: hw/rtl/frcs_front.sv
// Front end that tracks frame position, keeps the evaluated bytes and classifies each word.
`timescale 1ns / 1ps
module frcs_front #(
  parameter int FRAME_BYTES = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  input  logic              q_full,
  output logic              push,
  output frcs_pkg::frcs_cmd_t push_data
);
  import frcs_pkg::*;

  localparam int POS_W = $clog2(FRAME_BYTES + 1);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(FRAME_BYTES);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [7:0] hdr1;
  logic [7:0] hdr2;
  logic [7:0] hdr3;
  logic [7:0] addr_hi;
  logic [7:0] addr_lo;
  logic [7:0] cmd_byte;
  logic [7:0] eff1;
  logic [7:0] eff2;
  logic [7:0] eff3;
  logic [7:0] eff_hi;
  logic [7:0] eff_lo;
  logic [7:0] eff_cmd;
  logic is_start;
  logic is_end;
  logic accept;
  logic store_en;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept;
  assign is_start = (rx_byte == CH_START);
  assign is_end   = (rx_byte == CH_END);
  // Every byte but the start marker is stored at the current position; only the
  // positions that evaluation reads are kept.
  assign store_en = accept && !is_start;

  always_comb begin
    pos_next = pos;
    if (accept) begin
      if (is_start) begin
        pos_next = POS_W'(1);
      end else if (is_end) begin
        pos_next = '0;
      end else if (pos < POS_LIMIT) begin
        pos_next = pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      hdr1     <= '0;
      hdr2     <= '0;
      hdr3     <= '0;
      addr_hi  <= '0;
      addr_lo  <= '0;
      cmd_byte <= '0;
    end else begin
      pos <= pos_next;
      if (store_en && pos == POS_W'(POS_HDR1)) hdr1 <= rx_byte;
      if (store_en && pos == POS_W'(POS_HDR2)) hdr2 <= rx_byte;
      if (store_en && pos == POS_W'(POS_HDR3)) hdr3 <= rx_byte;
      if (store_en && pos == POS_W'(POS_ADDR_HI)) addr_hi <= rx_byte;
      if (store_en && pos == POS_W'(POS_ADDR_LO)) addr_lo <= rx_byte;
      if (store_en && pos == POS_W'(POS_CMD)) cmd_byte <= rx_byte;
    end
  end

  // The current byte is forwarded around the buffer, so evaluation need not wait for it.
  assign eff1    = (pos == POS_W'(POS_HDR1)) ? rx_byte : hdr1;
  assign eff2    = (pos == POS_W'(POS_HDR2)) ? rx_byte : hdr2;
  assign eff3    = (pos == POS_W'(POS_HDR3)) ? rx_byte : hdr3;
  assign eff_hi  = (pos == POS_W'(POS_ADDR_HI)) ? rx_byte : addr_hi;
  assign eff_lo  = (pos == POS_W'(POS_ADDR_LO)) ? rx_byte : addr_lo;
  assign eff_cmd = (pos == POS_W'(POS_CMD)) ? rx_byte : cmd_byte;

  always_comb begin
    push_data.frame_end = is_end;
    push_data.header_ok = (eff1 == CH_ONE) && (eff2 == CH_ZERO) && (eff3 == CH_D);
    push_data.addr      = {eff_hi, eff_lo};
    push_data.cmd_on    = (eff_cmd == CH_ONE);
    push_data.cmd_off   = (eff_cmd == CH_ZERO);
  end

endmodule

// File: hw/rtl/frcs_queue.sv
// Two-entry queue that decouples the front end from the relay back end.
`timescale 1ns / 1ps
module frcs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  frcs_pkg::frcs_cmd_t push_data,
  output logic                full,
  input  logic                pop,
  output frcs_pkg::frcs_cmd_t pop_data,
  output logic                not_empty
);
  import frcs_pkg::*;

  frcs_cmd_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count exceeds its depth");
  assert property (@(posedge clk) disable iff (rst) full |-> !push || pop)
    else $error("push into a full queue");
  assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("pop from an empty queue");

endmodule

// File: hw/rtl/frcs_back.sv
// Back end that holds the addresses, applies relay commands and drives the result word.
`timescale 1ns / 1ps
module frcs_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                q_not_empty,
  input  frcs_pkg::frcs_cmd_t q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                relay_one,
  output logic                relay_two,
  output logic                relay_three,
  output logic                frame_end
);
  import frcs_pkg::*;

  logic [15:0] address_one;
  logic [15:0] address_two;
  logic [15:0] address_three;
  logic [2:0]  relay_bits;
  logic [2:0]  relay_bits_next;
  logic [2:0]  match;
  logic        frame_end_reg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_one   <= ADDRESS_ONE_RST;
      address_two   <= ADDRESS_TWO_RST;
      address_three <= ADDRESS_THREE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ADDRESS_ONE:   address_one   <= cfg_data;
        REG_ADDRESS_TWO:   address_two   <= cfg_data;
        REG_ADDRESS_THREE: address_three <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pop = q_not_empty && (!out_valid || out_ready);

  assign match[0] = q_data.frame_end && q_data.header_ok && (q_data.addr == address_one);
  assign match[1] = q_data.frame_end && q_data.header_ok && (q_data.addr == address_two);
  assign match[2] = q_data.frame_end && q_data.header_ok && (q_data.addr == address_three);

  always_comb begin
    relay_bits_next = relay_bits;
    for (int i = 0; i < 3; i++) begin
      if (match[i] && q_data.cmd_on) begin
        relay_bits_next[i] = 1'b1;
      end else if (match[i] && q_data.cmd_off) begin
        relay_bits_next[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_bits    <= '0;
      out_valid     <= 1'b0;
      frame_end_reg <= 1'b0;
    end else begin
      if (pop) begin
        relay_bits    <= relay_bits_next;
        frame_end_reg <= q_data.frame_end;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign relay_one   = relay_bits[0];
  assign relay_two   = relay_bits[1];
  assign relay_three = relay_bits[2];
  assign frame_end   = frame_end_reg;

  assert property (@(posedge clk) disable iff (rst) !pop |=> $stable(relay_bits))
    else $error("relay state changed without a new word");
  assert property (@(posedge clk) disable iff (rst) pop && !q_data.frame_end |=>
                   $stable(relay_bits))
    else $error("relay state changed on a word that is not an end marker");
  assert property (@(posedge clk) disable iff (rst) pop |=> out_valid)
    else $error("popped word did not reach the output register");

endmodule

// File: hw/rtl/framed_command_relay_switch_core.sv
// An accepted word goes into the queue, then is popped into the output register.
// Throughput: one word per cycle with out_ready high; the two-entry queue and the
// output register let the input keep flowing while one result waits to be taken.
// Relays: 16-bit compare per relay on the queue head, one per cycle unless stalled.
// Reset (synchronous, active high) clears frame position, buffer, relays and queue,
// and loads the default relay addresses.
`timescale 1ns / 1ps
module framed_command_relay_switch_core #(
  parameter int FRAME_BYTES = frcs_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        relay_one,
  output logic        relay_two,
  output logic        relay_three,
  output logic        frame_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import frcs_pkg::*;

  frcs_cmd_t push_data;
  frcs_cmd_t q_data;
  logic      push;
  logic      q_full;
  logic      q_not_empty;
  logic      pop;

  frcs_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .push     (push),
    .push_data(push_data)
  );

  frcs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (pop),
    .pop_data (q_data),
    .not_empty(q_not_empty)
  );

  frcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_not_empty(q_not_empty),
    .q_data     (q_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .relay_one  (relay_one),
    .relay_two  (relay_two),
    .relay_three(relay_three),
    .frame_end  (frame_end)
  );

endmodule
